// File: src/npq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npq_pkg
// Shared types and constants of the nearest palette colour quantiser.
// ----------------------------------------------------------------------------
package npq_pkg;

  // Default palette depth (entries)
  localparam int PALETTE_DEPTH_DEF = 256;

  // Field widths
  localparam int CH_W      = 8;
  localparam int RGB_W     = 3 * CH_W;
  localparam int IDX_W     = 8;
  localparam int SQ_W      = 2 * CH_W;
  localparam int DIST_W    = SQ_W + 2;
  localparam int PALSZ_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = PALSZ_W;

  // Pixel channels keep their upper six bits
  localparam logic [CH_W-1:0] PIX_MASK = 8'hFC;

  // Register reset values
  localparam logic [PALSZ_W-1:0] PALSZ_RESET = 9'd256;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUANT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HAS_ALPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_ALPHA      = 2'd2;

  // Input item
  typedef struct packed {
    logic            opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [IDX_W-1:0] color_index;
    logic [CH_W-1:0]  alpha_out;
  } out_item_t;

  // One colour, also the layout of a palette word
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Tag travelling with each palette read
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // Search status back to the controller
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best_idx;
  } srch_stat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OUT
  } state_t;

endpackage

// File: src/nearest_palette_color_quantizer.sv
`timescale 1ns / 1ps
// Sequence: a quantise reads palette entries 0 to N - 1, N = palette size
//   (saturated to the depth), then loads the nearest index into the output
//   register; with an empty palette it loads index 0.
// Throughput: one quantise at a time, input stalls until its result is loaded;
//   the single palette read port gives one entry per cycle; writes go at one per cycle while idle.
// Reset: synchronous, active low; registers return to palette_size = 256 and
//   alpha flags clear. Palette contents are undefined until written.
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer
// Palette store, search sequencer and output register of the quantiser.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer #(
  parameter int PALETTE_DEPTH = npq_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  npq_pkg::in_item_t                in_data,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output npq_pkg::out_item_t               out_data,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [npq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [npq_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [npq_pkg::PALSZ_W-1:0] DEPTH_V = npq_pkg::PALSZ_W'(PALETTE_DEPTH);

  npq_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_sat;
  npq_pkg::rgb_t                pix_r;
  logic [npq_pkg::CH_W-1:0]     alpha_r;
  logic [npq_pkg::PALSZ_W-1:0]  pal_size_r;
  logic                         has_alpha_r;
  logic                         emit_alpha_r;
  npq_pkg::tag_t                rd_tag_r, rd_tag_nxt;
  logic                         out_valid_r;
  npq_pkg::out_item_t           out_data_r;
  npq_pkg::srch_stat_t          stat;
  npq_pkg::rgb_t                entry;
  npq_pkg::rgb_t                wr_rgb;
  logic [npq_pkg::RGB_W-1:0]    rd_word;
  logic                         in_xfer;
  logic                         wr_en;
  logic                         start;
  logic                         issue;
  logic                         out_free;
  logic                         out_load;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_size_r   <= npq_pkg::PALSZ_RESET;
      has_alpha_r  <= 1'b0;
      emit_alpha_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        npq_pkg::CFG_PALETTE_SIZE:    pal_size_r   <= cfg_data;
        npq_pkg::CFG_INPUT_HAS_ALPHA: has_alpha_r  <= cfg_data[0];
        npq_pkg::CFG_EMIT_ALPHA:      emit_alpha_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input transfer and palette writes
  assign in_stall = (state_r != npq_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign wr_en    = in_xfer && (in_data.opcode == npq_pkg::OP_WRITE)
                  && ({1'b0, in_data.entry_index} < DEPTH_V);
  assign count_sat = (pal_size_r > DEPTH_V) ? CW'(PALETTE_DEPTH) : CW'(pal_size_r);

  assign wr_rgb.red   = in_data.red;
  assign wr_rgb.green = in_data.green;
  assign wr_rgb.blue  = in_data.blue;

  npq_ram #(
    .WIDTH (npq_pkg::RGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.entry_index[AW-1:0]),
    .wr_data (wr_rgb),
    .rd_en   (issue),
    .rd_addr (rd_cnt_r[AW-1:0]),
    .rd_data (rd_word)
  );

  assign entry = rd_word;

  // search sequencer
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    start      = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      npq_pkg::ST_IDLE: begin
        if (in_xfer && (in_data.opcode == npq_pkg::OP_QUANT)) begin
          start      = 1'b1;
          rd_cnt_nxt = '0;
          state_nxt  = (count_sat == '0) ? npq_pkg::ST_OUT : npq_pkg::ST_SEARCH;
        end
      end
      npq_pkg::ST_SEARCH: begin
        issue = (rd_cnt_r < count_r);
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        if (stat.done) begin
          state_nxt = npq_pkg::ST_OUT;
        end
      end
      npq_pkg::ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = npq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_tag_nxt.vld  = issue;
    rd_tag_nxt.last = (rd_cnt_r == (count_r - CW'(1)));
    rd_tag_nxt.idx  = npq_pkg::IDX_W'(rd_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= npq_pkg::ST_IDLE;
      rd_cnt_r <= '0;
      rd_tag_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      rd_tag_r <= rd_tag_nxt;
    end
  end

  // pixel and alpha captured at transfer
  always_ff @(posedge clk) begin
    if (start) begin
      count_r     <= count_sat;
      pix_r.red   <= in_data.red   & npq_pkg::PIX_MASK;
      pix_r.green <= in_data.green & npq_pkg::PIX_MASK;
      pix_r.blue  <= in_data.blue  & npq_pkg::PIX_MASK;
      alpha_r     <= (emit_alpha_r && has_alpha_r) ? in_data.alpha_in : '0;
    end
  end

  npq_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .pix   (pix_r),
    .entry (entry),
    .tag   (rd_tag_r),
    .stat  (stat)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.color_index <= stat.best_idx;
      out_data_r.alpha_out   <= alpha_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/npq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module npq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/npq_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npq_dist
// Two-stage distance unit: squared channel differences, then sum and
// running minimum over the entries of one search.
// ----------------------------------------------------------------------------
module npq_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  npq_pkg::rgb_t       pix,
  input  npq_pkg::rgb_t       entry,
  input  npq_pkg::tag_t       tag,
  output npq_pkg::srch_stat_t stat
);

  logic [npq_pkg::SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  logic [npq_pkg::SQ_W-1:0]   sq_r_nxt, sq_g_nxt, sq_b_nxt;
  npq_pkg::tag_t              tag1_r;
  logic [npq_pkg::DIST_W-1:0] dist_sum;
  logic [npq_pkg::DIST_W-1:0] best_dist_r;
  logic [npq_pkg::IDX_W-1:0]  best_idx_r;
  logic                       have_best_r;
  logic                       done_r;

  // absolute difference, squared
  function automatic logic [npq_pkg::SQ_W-1:0] sq_diff(
    input logic [npq_pkg::CH_W-1:0] a,
    input logic [npq_pkg::CH_W-1:0] b
  );
    logic [npq_pkg::CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return npq_pkg::SQ_W'(d) * npq_pkg::SQ_W'(d);
  endfunction

  // stage 1: per-channel squares
  always_comb begin
    sq_r_nxt = sq_diff(entry.red,   pix.red);
    sq_g_nxt = sq_diff(entry.green, pix.green);
    sq_b_nxt = sq_diff(entry.blue,  pix.blue);
  end

  always_ff @(posedge clk) begin
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r <= tag;
    end
  end

  // stage 2: sum and keep the smallest, first index wins a tie
  assign dist_sum = npq_pkg::DIST_W'(sq_r_r) + npq_pkg::DIST_W'(sq_g_r)
                  + npq_pkg::DIST_W'(sq_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      best_idx_r  <= '0;
      done_r      <= 1'b0;
    end else if (start) begin
      have_best_r <= 1'b0;
      best_idx_r  <= '0;
      done_r      <= 1'b0;
    end else begin
      done_r <= tag1_r.vld && tag1_r.last;
      if (tag1_r.vld && (!have_best_r || (dist_sum < best_dist_r))) begin
        have_best_r <= 1'b1;
        best_idx_r  <= tag1_r.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag1_r.vld && (!have_best_r || (dist_sum < best_dist_r))) begin
      best_dist_r <= dist_sum;
    end
  end

  assign stat.done     = done_r;
  assign stat.best_idx = best_idx_r;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest palette colour quantiser. A short table
// of directed items (empty palette, alpha routing, truncation, ties, extreme
// slots) is followed by random phases. Each phase sets the registers while the
// block is idle, fills any active palette slot not yet written, then sends a
// mix of palette writes and quantise items in bursts. Results are compared
// field by field with a shadow model of the palette search, while the result
// side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
  import npq_pkg::*;

  localparam int ITEM_TARGET = 550;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYC  = 12;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // shadow of the block state
  rgb_t               palette_shadow [PALETTE_DEPTH_DEF];
  bit                 slot_written   [PALETTE_DEPTH_DEF];
  logic [PALSZ_W-1:0] size_shadow;
  logic               has_alpha_shadow;
  logic               emit_alpha_shadow;

  out_item_t          pending_results [$];
  stim_row_t          directed_rows [$];
  int                 fail_count;
  int                 items_sent;
  int                 burst_left;
  bit                 no_gaps;

  nearest_palette_color_quantizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("[nearest_palette_color_quantizer] ERROR");
    $finish;
  end

  function automatic int sq_gap(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // nearest active entry, lowest index on equal distance
  function automatic out_item_t predict_nearest(in_item_t px);
    int              count;
    int              best;
    int              best_dist;
    int              d;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    out_item_t       res;
    r = px.red & PIX_MASK;
    g = px.green & PIX_MASK;
    b = px.blue & PIX_MASK;
    count = (int'(size_shadow) > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : int'(size_shadow);
    best = 0;
    best_dist = 0;
    for (int i = 0; i < count; i++) begin
      d = sq_gap(palette_shadow[i].red, r) + sq_gap(palette_shadow[i].green, g)
        + sq_gap(palette_shadow[i].blue, b);
      if (i == 0 || d < best_dist) begin
        best = i;
        best_dist = d;
      end
    end
    res.color_index = best[IDX_W-1:0];
    res.alpha_out   = (emit_alpha_shadow && has_alpha_shadow) ? px.alpha_in : '0;
    return res;
  endfunction

  function automatic logic [CH_W-1:0] jitter(logic [CH_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 12)) - 6;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[CH_W-1:0];
  endfunction

  // random palette colour: plain, extreme channels, or a copy for ties
  function automatic rgb_t pick_colour();
    rgb_t c;
    int   j;
    case ($urandom_range(0, 3))
      0: begin
        c.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        j = $urandom_range(0, PALETTE_DEPTH_DEF - 1);
        c = slot_written[j] ? palette_shadow[j] : rgb_t'(RGB_W'($urandom));
      end
      default: c = rgb_t'(RGB_W'($urandom));
    endcase
    return c;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row = '{kind: ROW_CFG, default: '0};
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val[CFG_DAT_W-1:0];
    return row;
  endfunction

  function automatic stim_row_t wr_row(int slot, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b);
    stim_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind = ROW_ITEM;
    row.item = '{opcode: OP_WRITE, entry_index: slot[IDX_W-1:0], red: r, green: g,
                 blue: b, alpha_in: CH_W'($urandom_range(0, 255))};
    return row;
  endfunction

  function automatic stim_row_t qz_row(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b, logic [CH_W-1:0] a,
                                       bit typed, int idx, logic [CH_W-1:0] aout);
    stim_row_t row;
    row = '{kind: ROW_ITEM, default: '0};
    row.kind  = ROW_ITEM;
    row.item  = '{opcode: OP_QUANT, entry_index: IDX_W'($urandom_range(0, 255)), red: r,
                  green: g, blue: b, alpha_in: a};
    row.typed = typed;
    row.want  = '{color_index: idx[IDX_W-1:0], alpha_out: aout};
    return row;
  endfunction

  // one input transfer; state is updated at acceptance
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (it.opcode == OP_QUANT) begin
      pending_results.push_back(typed ? want : predict_nearest(it));
    end else begin
      palette_shadow[it.entry_index] = '{red: it.red, green: it.green, blue: it.blue};
      slot_written[it.entry_index]   = 1'b1;
    end
    items_sent++;
  endtask

  // bursts of random length with random gaps
  task automatic pace_sender();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = $urandom_range(1, 12);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // hold the sender until every expected result is in
  task automatic drain_results(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // register write, only once the block is idle
  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    drain_results(1'b1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DAT_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_PALETTE_SIZE:    size_shadow       = val[PALSZ_W-1:0];
      CFG_INPUT_HAS_ALPHA: has_alpha_shadow  = val[0];
      CFG_EMIT_ALPHA:      emit_alpha_shadow = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result stall pattern: free, random, held, sparse
  initial begin
    int mode;
    int len;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= 1'b1;
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result index %0d alpha %0h", $realtime,
                   out_data.color_index, out_data.alpha_out);
      end else begin
        want = pending_results.pop_front();
        if (out_data.color_index !== want.color_index ||
            out_data.alpha_out !== want.alpha_out) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch index exp %0d got %0d, alpha exp %0h got %0h",
                     $realtime, want.color_index, out_data.color_index,
                     want.alpha_out, out_data.alpha_out);
        end
      end
    end
  end

  // stimulus
  initial begin
    in_item_t  it;
    out_item_t none;
    stim_row_t row;
    int        new_size;
    int        n_active;
    int        seq_len;
    int        j;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PALETTE_SIZE;
    cfg_data  = '0;
    none      = '0;
    fail_count = 0;
    items_sent = 0;
    burst_left = 0;
    no_gaps    = 1'b0;
    size_shadow       = PALSZ_RESET;
    has_alpha_shadow  = 1'b0;
    emit_alpha_shadow = 1'b0;
    for (int i = 0; i < PALETTE_DEPTH_DEF; i++) begin
      slot_written[i]   = 1'b0;
      palette_shadow[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    // empty palette, alpha forced to zero by the reset flags
    directed_rows.push_back(cfg_row(CFG_PALETTE_SIZE, 0));
    directed_rows.push_back(qz_row(8'h12, 8'h34, 8'h56, 8'h5A, 1'b1, 0, 8'h00));
    directed_rows.push_back(cfg_row(CFG_INPUT_HAS_ALPHA, 1));
    directed_rows.push_back(qz_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0, 8'h00));
    // alpha passes only with both flags set
    directed_rows.push_back(cfg_row(CFG_EMIT_ALPHA, 1));
    directed_rows.push_back(qz_row(8'h00, 8'h00, 8'h00, 8'hA5, 1'b1, 0, 8'hA5));
    directed_rows.push_back(qz_row(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1, 0, 8'hFF));
    directed_rows.push_back(qz_row(8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 0, 8'h00));
    directed_rows.push_back(cfg_row(CFG_INPUT_HAS_ALPHA, 0));
    directed_rows.push_back(qz_row(8'h80, 8'h80, 8'h80, 8'hC3, 1'b1, 0, 8'h00));
    // small palette: black, white, black again, truncated white, red
    directed_rows.push_back(wr_row(0, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(wr_row(1, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(wr_row(2, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(wr_row(3, 8'hFC, 8'hFC, 8'hFC));
    directed_rows.push_back(wr_row(4, 8'hFF, 8'h00, 8'h00));
    directed_rows.push_back(cfg_row(CFG_PALETTE_SIZE, 1));
    directed_rows.push_back(qz_row(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 0, 8'h00));
    directed_rows.push_back(cfg_row(CFG_PALETTE_SIZE, 5));
    // truncation makes the pixel an exact hit on the truncated white
    directed_rows.push_back(qz_row(8'hFF, 8'hFF, 8'hFF, 8'h7E, 1'b1, 3, 8'h00));
    // equal distance to both black entries: lowest slot
    directed_rows.push_back(qz_row(8'h03, 8'h03, 8'h03, 8'h11, 1'b1, 0, 8'h00));
    directed_rows.push_back(qz_row(8'hFF, 8'h03, 8'h02, 8'h22, 1'b1, 4, 8'h00));
    directed_rows.push_back(cfg_row(CFG_INPUT_HAS_ALPHA, 1));
    directed_rows.push_back(qz_row(8'hFD, 8'hFE, 8'hFF, 8'h80, 1'b1, 3, 8'h80));
    directed_rows.push_back(qz_row(8'h7F, 8'h7F, 8'h7F, 8'h01, 1'b0, 0, 8'h00));
    directed_rows.push_back(wr_row(255, 8'h12, 8'h34, 8'h56));
    directed_rows.push_back(wr_row(5, 8'h7C, 8'h7C, 8'h7C));
    directed_rows.push_back(cfg_row(CFG_PALETTE_SIZE, 6));
    directed_rows.push_back(qz_row(8'h7F, 8'h7E, 8'h7D, 8'hFE, 1'b0, 0, 8'h00));

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        apply_cfg(row.reg_idx, int'(row.reg_val));
      end else begin
        push_item(row.item, row.typed, row.want);
        pace_sender();
      end
    end

    // random phases: full palette first, then the 9-bit maximum, then mixed
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      if (ph == 0) begin
        new_size = PALETTE_DEPTH_DEF;
      end else if (ph == 1) begin
        new_size = 511;
      end else begin
        j = $urandom_range(0, 99);
        if (j < 8)       new_size = 0;
        else if (j < 70) new_size = $urandom_range(1, 16);
        else if (j < 82) new_size = $urandom_range(17, 64);
        else if (j < 91) new_size = PALETTE_DEPTH_DEF;
        else             new_size = $urandom_range(PALETTE_DEPTH_DEF + 1, 511);
      end
      apply_cfg(CFG_PALETTE_SIZE, new_size);
      apply_cfg(CFG_INPUT_HAS_ALPHA, (ph == 0) ? 1 : $urandom_range(0, 1));
      apply_cfg(CFG_EMIT_ALPHA, (ph == 0) ? 1 : $urandom_range(0, 1));
      n_active   = (new_size > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : new_size;
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = 0;

      // no active slot may be searched before it is written
      for (int i = 0; i < n_active; i++) begin
        if (!slot_written[i]) begin
          it = '{opcode: OP_WRITE, entry_index: i[IDX_W-1:0], red: 8'h00, green: 8'h00,
                 blue: 8'h00, alpha_in: CH_W'($urandom_range(0, 255))};
          {it.red, it.green, it.blue} = pick_colour();
          push_item(it, 1'b0, none);
          pace_sender();
        end
      end

      seq_len = (n_active > 64) ? $urandom_range(3, 8) : $urandom_range(8, 30);
      for (int k = 0; k < seq_len; k++) begin
        if ($urandom_range(0, 99) < 30) begin
          j = (n_active > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n_active - 1)
                                                          : $urandom_range(0, 255);
          it = '{opcode: OP_WRITE, entry_index: j[IDX_W-1:0], red: 8'h00, green: 8'h00,
                 blue: 8'h00, alpha_in: CH_W'($urandom_range(0, 255))};
          {it.red, it.green, it.blue} = pick_colour();
        end else begin
          it = '{opcode: OP_QUANT, entry_index: IDX_W'($urandom_range(0, 255)),
                 red: CH_W'($urandom_range(0, 255)), green: CH_W'($urandom_range(0, 255)),
                 blue: CH_W'($urandom_range(0, 255)),
                 alpha_in: CH_W'($urandom_range(0, 255))};
          // mostly land close to a live entry so near ties are exercised
          if (n_active > 0 && $urandom_range(0, 2) != 0) begin
            j = $urandom_range(0, n_active - 1);
            it.red   = jitter(palette_shadow[j].red);
            it.green = jitter(palette_shadow[j].green);
            it.blue  = jitter(palette_shadow[j].blue);
          end
        end
        push_item(it, 1'b0, none);
        pace_sender();
        if (k == seq_len / 2 && (ph == 2 || $urandom_range(0, 3) == 0))
          drain_results(1'b0);
      end
    end

    // wind down
    drain_results(1'b1);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("[nearest_palette_color_quantizer] OK");
    else
      $display("[nearest_palette_color_quantizer] ERROR");
    $finish;
  end

endmodule
